### rtl/indexed_list_insert_delete_assert.svh
// ---------------------------------------------------------------------------
// Indexed list assertion macros
// Concurrent assertion shorthands for the indexed list store. Each macro
// expects a clock named clk and an active-high reset named rst in scope.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ILIST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("indexed list: assertion failed");

// Next-cycle implication, disabled during reset.
`define ILIST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("indexed list: assertion failed");

`endif

### rtl/ilist_pkg.sv
// ---------------------------------------------------------------------------
// Indexed list package
// Sizes, codes and shared types of the indexed list store.
// ---------------------------------------------------------------------------
package ilist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WORD_W   = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_INS_POS  = 3'd1,
    CMD_INS_HEAD = 3'd2,
    CMD_INS_TAIL = 3'd3,
    CMD_REMOVE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_t op;
    cmp_t     pos;
    word_t    wr_value;
  } cell_ctrl_t;

  // Outcome of one request, from the decoder to the top level.
  typedef struct packed {
    status_t status;
    count_t  count_next;
    logic    is_read;
    logic    read_hit;
  } req_res_t;

endpackage

### rtl/ilist_cell.sv
// ---------------------------------------------------------------------------
// Indexed list cell
// One entry of the list. Takes its lower or upper neighbour's word on a
// shift, the new word at the insert point, and otherwise holds.
// ---------------------------------------------------------------------------
module ilist_cell (
  input  logic                clk,
  input  ilist_pkg::cell_ctrl_t ctrl,
  input  ilist_pkg::cmp_t     index,
  input  ilist_pkg::word_t    left,
  input  ilist_pkg::word_t    right,
  output ilist_pkg::word_t    value
);
  import ilist_pkg::*;

  word_t value_next;

  always_comb begin
    value_next = value;
    case (ctrl.op)
      OP_INSERT: begin
        if (index == ctrl.pos) begin
          value_next = ctrl.wr_value;
        end else if (index > ctrl.pos) begin
          value_next = left;
        end
      end
      OP_REMOVE: begin
        if (index >= ctrl.pos) begin
          value_next = right;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### rtl/ilist_ctrl.sv
// ---------------------------------------------------------------------------
// Indexed list request decoder
// Checks a request against the entry count and drives the cell row.
// ---------------------------------------------------------------------------
module ilist_ctrl (
  input  logic                  exec,
  input  logic [2:0]            command,
  input  logic [4:0]            position,
  input  ilist_pkg::word_t      new_value,
  input  ilist_pkg::count_t     count,
  output ilist_pkg::cell_ctrl_t ctrl,
  output ilist_pkg::req_res_t   res
);
  import ilist_pkg::*;

  cmp_t pos_ext;
  cmp_t cnt_ext;
  cmp_t cap_ext;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count);
  assign cap_ext = CMP_W'(CAPACITY);

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.pos      = pos_ext;
    ctrl.wr_value = new_value;
    res.status     = ST_DONE;
    res.count_next = count;
    res.is_read    = 1'b0;
    res.read_hit   = 1'b0;
    unique case (cmd_t'(command)) inside
      CMD_READ: begin
        res.is_read = 1'b1;
        if (pos_ext >= cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          res.read_hit = 1'b1;
        end
      end
      CMD_INS_POS, CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (cmd_t'(command) == CMD_INS_HEAD) begin
          ctrl.pos = '0;
        end else if (cmd_t'(command) == CMD_INS_TAIL) begin
          ctrl.pos = cnt_ext;
        end
        if (ctrl.pos > cnt_ext) begin
          res.status = ST_RANGE;
        end else if (cnt_ext >= cap_ext) begin
          res.status = ST_FULL;
        end else begin
          ctrl.op        = exec ? OP_INSERT : OP_HOLD;
          res.count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          ctrl.op        = exec ? OP_REMOVE : OP_HOLD;
          res.count_next = count - CNT_W'(1);
        end
      end
      default: begin
        // unknown codes: ignore
      end
    endcase
  end

endmodule

### rtl/indexed_list_insert_delete.sv
// ---------------------------------------------------------------------------
// Indexed list store
// Ordered list of up to CAPACITY signed 32-bit words held in a row of
// cells; read, insert (at a position, head or tail) and remove by position.
// ---------------------------------------------------------------------------
//
//  channel   handshake        payload
//  --------  ---------------  ----------------------------------------
//  request   start / busy     command, position, new_value
//  result    done (strobe)    read_value, status, entry_count
//
//  A request transfers on a clock edge with start high and busy low.
//  Each request is first captured, then executed: in the execute state the
//  cell row shifts and the result is registered; done is high in the
//  cycle after that, which may overlap the next request's capture.
//  Reset clears the entry count and the control state; entries are left
//  undefined and are never read until written. The result cannot stall.
//
module indexed_list_insert_delete (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic [4:0]         position,
  input  logic signed [31:0] new_value,
  output logic               done,
  output logic signed [31:0] read_value,
  output logic [1:0]         status,
  output logic [4:0]         entry_count
);
  import ilist_pkg::*;

  fsm_t       state;
  fsm_t       state_next;
  logic       accept;

  // captured request
  logic [2:0] cmd_q;
  logic [4:0] pos_q;
  word_t      val_q;

  count_t     count;
  cell_ctrl_t ctrl;
  req_res_t   res;
  cmp_t       cnt_ext;

  word_t      cell_val [CAPACITY];
  word_t      rd_word;

  // Request handshake and sequencing: capture, then execute.
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (start) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        busy       = 1'b1;
        state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request for the execute cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      pos_q <= position;
      val_q <= word_t'(new_value);
    end
  end

  ilist_ctrl u_ctrl (
    .exec      (state == FSM_EXEC),
    .command   (cmd_q),
    .position  (pos_q),
    .new_value (val_q),
    .count     (count),
    .ctrl      (ctrl),
    .res       (res)
  );

  // Row of cells; each passes its word up on insert and down on remove.
  // The ends take words that are never kept inside the list.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilist_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .index (CMP_W'(g)),
      .left  ((g == 0) ? ctrl.wr_value : cell_val[(g == 0) ? 0 : g - 1]),
      .right ((g == CAPACITY - 1) ? cell_val[g]
                                  : cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .value (cell_val[g])
    );
  end

  // Read selection; only used when the position is within the count.
  assign rd_word = cell_val[IDX_W'(pos_q)];

  // Advance the count on the execute cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == FSM_EXEC) begin
      count <= res.count_next;
    end
  end

  assign cnt_ext = CMP_W'(res.count_next);

  // Register the result; done strobes for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == FSM_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == FSM_EXEC) begin
      status      <= res.status;
      entry_count <= cnt_ext[4:0];
      if (!res.is_read) begin
        read_value <= '0;
      end else if (res.read_hit) begin
        read_value <= $signed(rd_word);
      end else begin
        read_value <= -32'sd1;
      end
    end
  end

  `include "indexed_list_insert_delete_assert.svh"

  `ILIST_ASSERT_NOW(a_count_bound, 1'b1, CMP_W'(count) <= CMP_W'(CAPACITY))
  `ILIST_ASSERT_NEXT(a_accept_busy, accept, busy && !done)
  `ILIST_ASSERT_NOW(a_done_after_exec, done, $past(busy))
  `ILIST_ASSERT_NOW(a_full_count, done && (status == ST_FULL),
                    count == CNT_W'(CAPACITY))
  `ILIST_ASSERT_NEXT(a_idle_count, state == FSM_IDLE, $stable(count))

endmodule
